### sv/power_button_controller_assert.svh
// ----------------------------------------------------------------------------
// Power button controller assertion macros
// Shared macros for the concurrent checks of the power button controller.
// ----------------------------------------------------------------------------
`ifndef POWER_BUTTON_CONTROLLER_ASSERT_SVH
`define POWER_BUTTON_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("power button controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("power button controller check failed");

`endif

### sv/pbc_pkg.sv
// ----------------------------------------------------------------------------
// Power button controller package
// Payload and configuration types, register indexes and reset values.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 16;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SHORT_PRESS_TICKS = 2'd0,
        CFG_LONG_PRESS_TICKS  = 2'd1,
        CFG_HOST_TIMEOUT_MS   = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  ShortPressReset  = 8'd10;
    localparam logic [7:0]  LongPressReset   = 8'd200;
    localparam logic [15:0] HostTimeoutReset = 16'd15000;

    // Power state codes.
    localparam logic [7:0] StateOff      = 8'd0;
    localparam logic [7:0] StateOn       = 8'd1;
    localparam logic [7:0] StateKeyDown  = 8'd2;
    localparam logic [7:0] StateShutdown = 8'd3;
    localparam logic [7:0] StateForced   = 8'd4;
    localparam logic [7:0] StateMax      = 8'd255;

    typedef struct packed {
        logic        button_level;
        logic [15:0] ms_since_host;
    } t_in;

    typedef struct packed {
        logic       hold_power;
        logic       cut_power;
        logic [7:0] pwr_mode;
    } t_out;

    typedef struct packed {
        logic [7:0]  short_press_ticks;
        logic [7:0]  long_press_ticks;
        logic [15:0] host_timeout_ms;
    } t_cfg;

endpackage

### sv/pbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Power button controller configuration registers
// Holds the press thresholds and the host timeout written over the cfg port.
// ----------------------------------------------------------------------------
module pbc_cfg_regs
    import pbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_wdata,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_press_ticks <= ShortPressReset;
            r_cfg.long_press_ticks  <= LongPressReset;
            r_cfg.host_timeout_ms   <= HostTimeoutReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT_PRESS_TICKS: begin
                    r_cfg.short_press_ticks <= i_cfg_wdata[7:0];
                end
                CFG_LONG_PRESS_TICKS: begin
                    r_cfg.long_press_ticks <= i_cfg_wdata[7:0];
                end
                CFG_HOST_TIMEOUT_MS: begin
                    r_cfg.host_timeout_ms <= i_cfg_wdata;
                end
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/pbc_core.sv
// ----------------------------------------------------------------------------
// Power button controller core
// Hold counter, button history and power state, updated once per tick.
// ----------------------------------------------------------------------------
module pbc_core
    import pbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    logic [7:0] r_hold_count, n_hold_count;
    logic       r_prev_level;
    logic [7:0] r_mode, n_mode;
    logic [7:0] r_saved_mode, n_saved_mode;
    logic       hold;
    logic       cut;
    logic       at_long;

    assign at_long = (r_hold_count == i_cfg.long_press_ticks);

    always_comb begin
        n_hold_count = r_hold_count;
        n_mode       = r_mode;
        n_saved_mode = r_saved_mode;
        hold         = 1'b0;
        cut          = 1'b0;
        if (!i_item.button_level && !r_prev_level) begin
            // Continued press.
            if (r_hold_count == i_cfg.short_press_ticks) begin
                n_saved_mode = r_mode;
                n_mode       = StateKeyDown;
            end
            if (r_hold_count < i_cfg.long_press_ticks) begin
                n_hold_count = r_hold_count + 8'd1;
            end else begin
                hold = 1'b1;
            end
        end else begin
            // Release or first pressed tick.
            n_mode = r_saved_mode;
            if (r_saved_mode >= StateShutdown) begin
                if (at_long && r_saved_mode != StateMax) begin
                    n_mode = r_saved_mode + 8'd1;
                end
                if (n_mode >= StateForced ||
                    i_item.ms_since_host > i_cfg.host_timeout_ms) begin
                    cut = 1'b1;
                end
                n_saved_mode = n_mode;
            end else if (at_long) begin
                n_mode       = (r_saved_mode == StateOff) ? StateOn : StateShutdown;
                n_saved_mode = n_mode;
            end
            n_hold_count = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count <= 8'd0;
            r_prev_level <= 1'b0;
            r_mode       <= StateOff;
            r_saved_mode <= StateOff;
        end else if (i_fire) begin
            r_hold_count <= n_hold_count;
            r_prev_level <= i_item.button_level;
            r_mode       <= n_mode;
            r_saved_mode <= n_saved_mode;
        end
    end

    assign o_result.hold_power = hold;
    assign o_result.cut_power  = cut;
    assign o_result.pwr_mode   = n_mode;

endmodule

### sv/power_button_controller.sv
// ----------------------------------------------------------------------------
// Power button controller
// Debounced hold timing of the power button and the power state sequence.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   -------   ---------  ------------------  ------------------------------
//   tick in   input      i_valid / o_stall   i_data  (button level, silence)
//   result    output     o_valid / i_stall   o_data  (hold, cut, state)
//   config    input      i_cfg_we            i_cfg_idx, i_cfg_wdata
//
// Every tick passes through the input register and then through the state
// update into the result register. A new tick can be transferred in every
// cycle while o_stall is low; the state updates as a tick leaves the input
// register, so back-to-back ticks see each other's effect.
// Reset is synchronous and active low. It clears the valid flags, the hold
// counter, the button history and both mode registers, and loads the
// register defaults.
// A stall on the result side holds the result register; the input register
// keeps its tick and o_stall rises only when both stages are full.
//
module power_button_controller
    import pbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_in                     i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out                    o_data,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_wdata
);

`include "power_button_controller_assert.svh"

    t_cfg cfg;
    t_out result;

    // Input register stage.
    logic r_s1_valid;
    t_in  r_s1_data;

    // Result register stage.
    logic r_out_valid;
    t_out r_out_data;

    logic out_blocked;
    logic advance;

    // The result register is blocked only while it is full and stalled.
    assign out_blocked = r_out_valid && i_stall;
    // A tick leaves the input register and updates the state on this edge.
    assign advance     = r_s1_valid && !out_blocked;
    assign o_stall     = r_s1_valid && out_blocked;

    pbc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pbc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_s1_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s1_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Power is never held and cut on the same tick.
    `PBC_ASSERT_SAME(a_hold_cut_excl, i_clk, i_rst_n, o_valid,
                     !(o_data.hold_power && o_data.cut_power))
    // Cutting power only happens in shutdown or forced-off states.
    `PBC_ASSERT_SAME(a_cut_state, i_clk, i_rst_n, o_valid && o_data.cut_power,
                     o_data.pwr_mode >= StateShutdown)
    // A transferred tick is held in the input register on the next cycle.
    `PBC_ASSERT_NEXT(a_s1_load, i_clk, i_rst_n, i_valid && !o_stall, r_s1_valid)
    // A tick that advances always produces a result on the next cycle.
    `PBC_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, advance, o_valid)

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Power button controller testbench
// Sends button ticks through the valid/stall channels and compares every
// result with a cycle-free model of the hold counter and the power states.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbc_pkg::*;

    localparam int ClkPeriodNs    = 4;
    localparam int HoldOffCycles  = 80;
    localparam int SettleCycles   = 3;
    localparam int TailCycles     = 10;
    localparam int WatchdogNs     = 2_000_000;

    // Tracks the expected behavior of the controller. Every accepted tick
    // advances the tracked state and queues the result that it must produce;
    // every accepted result is matched against the oldest queued one.
    class pbc_tracker;
        t_cfg        cfg;
        logic [7:0]  hold_count;
        logic        prev_level;
        logic [7:0]  mode;
        logic [7:0]  saved_mode;
        t_out        pending_outputs[$];
        int unsigned failures;

        function new();
            cfg.short_press_ticks = ShortPressReset;
            cfg.long_press_ticks  = LongPressReset;
            cfg.host_timeout_ms   = HostTimeoutReset;
            hold_count = '0;
            prev_level = 1'b0;
            mode       = StateOff;
            saved_mode = StateOff;
            failures   = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_SHORT_PRESS_TICKS: cfg.short_press_ticks = value[7:0];
                CFG_LONG_PRESS_TICKS:  cfg.long_press_ticks  = value[7:0];
                CFG_HOST_TIMEOUT_MS:   cfg.host_timeout_ms   = value;
                default: ;
            endcase
        endfunction

        function void note_tick(t_in tick);
            t_out res;
            res.hold_power = 1'b0;
            res.cut_power  = 1'b0;
            if (!tick.button_level && !prev_level) begin
                // Continued press: the key-down report, then the counter.
                if (hold_count == cfg.short_press_ticks) begin
                    saved_mode = mode;
                    mode = StateKeyDown;
                end
                if (hold_count < cfg.long_press_ticks) begin
                    hold_count++;
                end else begin
                    res.hold_power = 1'b1;
                end
            end else begin
                // Release or the first tick of a press.
                mode = saved_mode;
                if (mode >= StateShutdown) begin
                    if (hold_count == cfg.long_press_ticks && mode != StateMax) begin
                        mode++;
                    end
                    if (mode >= StateForced || tick.ms_since_host > cfg.host_timeout_ms) begin
                        res.cut_power = 1'b1;
                    end
                    saved_mode = mode;
                end else if (hold_count == cfg.long_press_ticks) begin
                    mode = (mode == StateOff) ? StateOn : StateShutdown;
                    saved_mode = mode;
                end
                hold_count = '0;
            end
            prev_level = tick.button_level;
            res.pwr_mode = mode;
            pending_outputs.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_outputs.size() == 0) begin
                failures++;
                $error("result transfer with no tick outstanding: %h", got);
                return;
            end
            want = pending_outputs.pop_front();
            if (got.hold_power !== want.hold_power) begin
                failures++;
                $error("hold_power: expected %0d, got %0d", want.hold_power, got.hold_power);
            end
            if (got.cut_power !== want.cut_power) begin
                failures++;
                $error("cut_power: expected %0d, got %0d", want.cut_power, got.cut_power);
            end
            if (got.pwr_mode !== want.pwr_mode) begin
                failures++;
                $error("pwr_mode: expected %0d, got %0d",
                       want.pwr_mode, got.pwr_mode);
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    tick_valid   = 1'b0;
    logic                    tick_stall;
    t_in                     tick_in      = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    t_out                    result_out;
    logic                    cfg_we       = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_idx      = CFG_SHORT_PRESS_TICKS;
    logic [CfgDataWidth-1:0] cfg_wdata    = '0;

    pbc_tracker tracker = new();

    // Shared between the stimulus and the result side: a window in which
    // neither side idles, and a request for one long receiver hold-off.
    bit          quiet_stretch    = 1'b0;
    bit          hold_off_request = 1'b0;
    int unsigned hold_off_left    = 0;

    power_button_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (tick_valid),
        .o_stall     (tick_stall),
        .i_data      (tick_in),
        .o_valid     (result_valid),
        .i_stall     (result_stall),
        .o_data      (result_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #(ClkPeriodNs / 2) clk = ~clk;

    // Result side. The handshake is judged on the values that stood before
    // the edge; the stall for the next cycle is then chosen. A requested
    // hold-off is counted out here, so the sender keeps offering ticks until
    // both pipeline stages are full and the block stalls its input.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            tracker.check_result(result_out);
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            result_stall <= 1'b1;
        end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left = HoldOffCycles - 1;
            result_stall <= 1'b1;
        end else begin
            result_stall <= !quiet_stretch && ($urandom_range(0, 99) < 9);
        end
    end

    // Silence values: anything in the field's range, values right at the
    // host timeout (to tell "equal" from "greater"), and short ones.
    function automatic logic [15:0] pick_silence();
        int v;
        int unsigned r;
        r = $urandom_range(0, 9);
        v = int'(tracker.cfg.host_timeout_ms);
        if (r < 4) begin
            v = int'($urandom_range(0, 65535));
        end else if (r < 7) begin
            v = v + int'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
        end else begin
            v = int'($urandom_range(0, 100));
        end
        return 16'(v);
    endfunction

    // Offers one tick, with random idle cycles ahead of it, and holds the
    // payload until the transfer. The tracker learns of the tick only once
    // it has been taken.
    task automatic offer_tick(input logic level, input logic [15:0] silence);
        t_in tick;
        tick.button_level  = level;
        tick.ms_since_host = silence;
        while (!quiet_stretch && $urandom_range(0, 99) < 9) begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_in    <= tick;
        do @(posedge clk); while (tick_stall);
        tracker.note_tick(tick);
    endtask

    task automatic press_sequence(input int unsigned held, input int unsigned released);
        repeat (held) offer_tick(1'b0, pick_silence());
        repeat (released) offer_tick(1'b1, pick_silence());
    endtask

    // Registers change only with the block idle: the sender stops, every
    // expected result must have arrived, and a few more cycles pass. The
    // upper byte of the write data for the 8-bit registers is random, since
    // only the low byte is kept.
    task automatic apply_thresholds(input logic [7:0] short_t, input logic [7:0] long_t,
                                    input logic [15:0] timeout);
        tick_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SHORT_PRESS_TICKS;
        cfg_wdata <= {8'($urandom_range(0, 255)), short_t};
        @(posedge clk);
        cfg_idx   <= CFG_LONG_PRESS_TICKS;
        cfg_wdata <= {8'($urandom_range(0, 255)), long_t};
        @(posedge clk);
        cfg_idx   <= CFG_HOST_TIMEOUT_MS;
        cfg_wdata <= timeout;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_register(CFG_SHORT_PRESS_TICKS, {8'd0, short_t});
        tracker.set_register(CFG_LONG_PRESS_TICKS, {8'd0, long_t});
        tracker.set_register(CFG_HOST_TIMEOUT_MS, timeout);
    endtask

    // Mostly whole presses whose lengths sit around the current thresholds,
    // each followed by a short release; the rest is random level noise that
    // cuts presses off at odd points.
    task automatic run_press_phase(input int unsigned n_ticks);
        int unsigned sent;
        int unsigned held;
        int unsigned rel;
        int unsigned short_t;
        int unsigned long_t;
        sent    = 0;
        short_t = tracker.cfg.short_press_ticks;
        long_t  = tracker.cfg.long_press_ticks;
        while (sent < n_ticks) begin
            held = 0;
            rel  = $urandom_range(1, 3);
            case ($urandom_range(0, 4))
                0: begin
                    held = $urandom_range(1, 4);
                end
                1: begin
                    held = long_t + $urandom_range(0, 3);
                end
                2: begin
                    held = short_t + $urandom_range(1, 3);
                end
                3: begin
                    held = $urandom_range(1, long_t + 4);
                end
                default: begin
                    rel = 0;
                    repeat ($urandom_range(1, 3)) begin
                        offer_tick(1'($urandom_range(0, 1)), pick_silence());
                        sent++;
                    end
                end
            endcase
            press_sequence(held, rel);
            sent += held + rel;
        end
    endtask

    initial begin
        int unsigned seq_no;
        int unsigned after_max;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults. The button history resets to pressed, so a
        // pressed first tick already counts as a continued press.
        offer_tick(1'b0, 16'd0);
        offer_tick(1'b0, 16'hFFFF);
        offer_tick(1'b1, HostTimeoutReset);
        offer_tick(1'b1, HostTimeoutReset + 16'd1);

        // Thresholds changed in the middle of a press: the counter is left
        // above the new long threshold, so the button keeps asserting
        // hold-power and the release is not taken as a long press.
        repeat (5) offer_tick(1'b0, 16'($urandom_range(0, 65535)));
        apply_thresholds(8'd3, 8'd2, 16'd0);
        offer_tick(1'b0, 16'd0);
        offer_tick(1'b1, 16'd0);

        // Smallest thresholds: long press turns the power on, then a long
        // press with key down requests shutdown. In shutdown, silence equal
        // to the timeout keeps power and one more cuts it; another long
        // press forces power off.
        apply_thresholds(8'd1, 8'd1, 16'd0);
        press_sequence(2, 1);
        press_sequence(3, 1);
        offer_tick(1'b1, 16'd0);
        offer_tick(1'b1, 16'd1);
        press_sequence(2, 1);

        // Short threshold above the long one (key down never fires), then
        // both equal, then random small settings.
        apply_thresholds(8'd9, 8'd4, 16'hFFFF);
        run_press_phase(30);
        apply_thresholds(8'd5, 8'd5, 16'd100);
        run_press_phase(30);
        repeat (2) begin
            apply_thresholds(8'($urandom_range(1, 12)), 8'($urandom_range(1, 16)),
                             16'($urandom_range(0, 65535)));
            run_press_phase(30);
        end

        // Largest thresholds: one press held past the counter ceiling, where
        // the key-down report repeats on every held tick.
        apply_thresholds(8'd255, 8'd255, 16'hFFFF);
        press_sequence(260, 0);
        offer_tick(1'b1, 16'hFFFF);
        offer_tick(1'b1, 16'hFFFF);

        // Back-to-back long presses drive the forced-off state up to its
        // ceiling and beyond. The short threshold sits above the long one,
        // so key down stays quiet and the state only climbs. Somewhere in
        // here the receiver holds off for a long stretch, and later a window
        // runs with no idling at all.
        apply_thresholds(8'($urandom_range(2, 3)), 8'd1, 16'($urandom_range(0, 65535)));
        seq_no    = 0;
        after_max = 0;
        while (after_max < 10) begin
            seq_no++;
            if (seq_no == 30) hold_off_request = 1'b1;
            quiet_stretch = (seq_no >= 60 && seq_no < 120);
            if (tracker.mode == StateMax) after_max++;
            if ($urandom_range(0, 9) == 0) begin
                offer_tick(1'($urandom_range(0, 1)), pick_silence());
            end else begin
                press_sequence(2, 1);
            end
        end
        quiet_stretch = 1'b0;

        // Let the last results drain, then allow a few cycles for anything
        // stray to show up.
        tick_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_outputs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(WatchdogNs);
        $display("TEST FAILED");
        $finish;
    end

endmodule
